### hw/rtl/dtf_pkg.sv
// Shared types, constants and codes for the disk request task-file block.
package dtf_pkg;

  // Block geometry (block and sector sizes are powers of two)
  localparam int BLOCK_BYTES     = 1024;
  localparam int SECTOR_BYTES    = 512;
  localparam int DEVICE_SLOTS    = 10;
  localparam int SLOTS_PER_DRIVE = 5;

  localparam int PER_BLOCK    = BLOCK_BYTES / SECTOR_BYTES;
  localparam int BLOCK_SHIFT  = $clog2(BLOCK_BYTES);
  localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
  localparam int SLOT_W       = $clog2(DEVICE_SLOTS);

  // Field widths
  localparam int CMD_W    = 2;
  localparam int DEV_W    = 4;
  localparam int COUNT_W  = 16;
  localparam int OFFSET_W = 31;
  localparam int WORD_W   = 32;
  localparam int HEADS_W  = 5;
  localparam int SECS_W   = 8;
  localparam int BYTE_W   = 8;
  localparam int CYL_W    = 10;

  // Derived arithmetic widths
  localparam int SECIDX_W = OFFSET_W - SECTOR_SHIFT;
  localparam int SECTOR_W = WORD_W + 1;
  localparam int TRACK_W  = HEADS_W + SECS_W;
  localparam int STEP_W   = $clog2(SECTOR_W + 1);

  // Queue between the front and back parts
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration port
  localparam int ADDR_W  = 5;
  localparam int PDATA_W = 32;

  // Task-file constants
  localparam logic [BYTE_W-1:0] DH_BASE  = 8'hA0;
  localparam logic [BYTE_W-1:0] OP_READ  = 8'h20;
  localparam logic [BYTE_W-1:0] OP_WRITE = 8'h30;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ    = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_LOAD    = 2'd2,
    CMD_INVALID = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EIO    = 2'd1,
    ST_EINVAL = 2'd2,
    ST_EOF    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_DRIVE_COUNT    = 3'd0,
    REG_HEADS_FIRST    = 3'd1,
    REG_SECTORS_FIRST  = 3'd2,
    REG_PRECOMP_FIRST  = 3'd3,
    REG_HEADS_SECOND   = 3'd4,
    REG_SECTORS_SECOND = 3'd5,
    REG_PRECOMP_SECOND = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    BACK_IDLE,
    BACK_CYL,
    BACK_HEAD,
    BACK_HOLD
  } back_state_t;

  typedef struct packed {
    logic [1:0]         drive_count;
    logic [HEADS_W-1:0] heads_first;
    logic [SECS_W-1:0]  sectors_first;
    logic [BYTE_W-1:0]  precomp_first;
    logic [HEADS_W-1:0] heads_second;
    logic [SECS_W-1:0]  sectors_second;
    logic [BYTE_W-1:0]  precomp_second;
  } cfg_t;

  // Classified word handed from the front to the back
  typedef struct packed {
    logic                immediate;
    status_t             status;
    logic                drive;
    logic                write;
    logic [BYTE_W-1:0]   precomp;
    logic [HEADS_W-1:0]  heads;
    logic [SECS_W-1:0]   secs;
    logic [SECTOR_W-1:0] sector;
  } job_t;

  typedef struct packed {
    logic                start;
    logic [SECTOR_W-1:0] dividend;
    logic [TRACK_W-1:0]  divisor;
    logic [STEP_W-1:0]   steps;
  } div_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [SECTOR_W-1:0] quotient;
    logic [TRACK_W-1:0]  remainder;
  } div_rsp_t;

endpackage

### hw/rtl/dtf_req_if.sv
// Request channel interface: valid, ready and the request word.
interface dtf_req_if;
  logic                          valid;
  logic                          ready;
  logic [dtf_pkg::CMD_W-1:0]     command;
  logic [dtf_pkg::DEV_W-1:0]     device;
  logic [dtf_pkg::COUNT_W-1:0]   byte_count;
  logic [dtf_pkg::OFFSET_W-1:0]  byte_offset;
  logic [dtf_pkg::WORD_W-1:0]    entry_start;
  logic [dtf_pkg::WORD_W-1:0]    entry_length;

  modport source (output valid, command, device, byte_count, byte_offset,
                  entry_start, entry_length, input ready);
  modport sink (input valid, command, device, byte_count, byte_offset,
                entry_start, entry_length, output ready);
endinterface

### hw/rtl/dtf_res_if.sv
// Result channel interface: valid, ready and the task-file word.
interface dtf_res_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [3:0]                  control_byte;
  logic [dtf_pkg::BYTE_W-1:0]  precomp_byte;
  logic [dtf_pkg::BYTE_W-1:0]  sector_count;
  logic [dtf_pkg::BYTE_W-1:0]  sector_number;
  logic [dtf_pkg::BYTE_W-1:0]  cylinder_low;
  logic [1:0]                  cylinder_high;
  logic [dtf_pkg::BYTE_W-1:0]  drive_head;
  logic [dtf_pkg::BYTE_W-1:0]  opcode_byte;

  modport source (output valid, status, control_byte, precomp_byte, sector_count,
                  sector_number, cylinder_low, cylinder_high, drive_head,
                  opcode_byte, input ready);
  modport sink (input valid, status, control_byte, precomp_byte, sector_count,
                sector_number, cylinder_low, cylinder_high, drive_head,
                opcode_byte, output ready);
endinterface

### hw/rtl/disk_request_to_chs_task_file.sv
// Top level: configuration registers, front, queue and back of the task-file block.
//
// Each request word yields one task-file word. Rejected requests, partition
// loads and invalid commands go through the queue straight to the result
// register. A read or write that passes its checks takes 33 steps of the
// shared iterative divider to split the absolute sector by the track size,
// 13 steps to split the remainder into head and sector, and a handoff to the
// result register; the back part takes no new request until then. A two-word
// queue lets the front keep accepting and classifying while the back part
// divides. Configuration is an APB-style port with seven 32-bit registers at
// byte addresses 0 to 24.
module disk_request_to_chs_task_file (
  input  logic                         clk,
  input  logic                         rst,
  dtf_req_if.sink                      request,
  dtf_res_if.source                    result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dtf_pkg::ADDR_W-1:0]   paddr,
  input  logic [dtf_pkg::PDATA_W-1:0]  pwdata,
  output logic [dtf_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  dtf_pkg::cfg_t     cfg;
  dtf_pkg::reg_idx_t reg_idx;
  logic              cfg_write;

  logic          push;
  dtf_pkg::job_t push_job;
  logic          q_full;
  logic          pop;
  dtf_pkg::job_t head_job;
  logic          q_empty;

  assign pready    = 1'b1;
  assign reg_idx   = dtf_pkg::reg_idx_t'(paddr[dtf_pkg::ADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drive_count    <= '0;
      cfg.heads_first    <= dtf_pkg::HEADS_W'(1);
      cfg.sectors_first  <= dtf_pkg::SECS_W'(1);
      cfg.precomp_first  <= '0;
      cfg.heads_second   <= dtf_pkg::HEADS_W'(1);
      cfg.sectors_second <= dtf_pkg::SECS_W'(1);
      cfg.precomp_second <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        dtf_pkg::REG_DRIVE_COUNT:    cfg.drive_count    <= pwdata[1:0];
        dtf_pkg::REG_HEADS_FIRST:    cfg.heads_first    <= pwdata[dtf_pkg::HEADS_W-1:0];
        dtf_pkg::REG_SECTORS_FIRST:  cfg.sectors_first  <= pwdata[dtf_pkg::SECS_W-1:0];
        dtf_pkg::REG_PRECOMP_FIRST:  cfg.precomp_first  <= pwdata[dtf_pkg::BYTE_W-1:0];
        dtf_pkg::REG_HEADS_SECOND:   cfg.heads_second   <= pwdata[dtf_pkg::HEADS_W-1:0];
        dtf_pkg::REG_SECTORS_SECOND: cfg.sectors_second <= pwdata[dtf_pkg::SECS_W-1:0];
        dtf_pkg::REG_PRECOMP_SECOND: cfg.precomp_second <= pwdata[dtf_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // Configuration register reads
  always_comb begin
    unique case (reg_idx)
      dtf_pkg::REG_DRIVE_COUNT:    prdata = dtf_pkg::PDATA_W'(cfg.drive_count);
      dtf_pkg::REG_HEADS_FIRST:    prdata = dtf_pkg::PDATA_W'(cfg.heads_first);
      dtf_pkg::REG_SECTORS_FIRST:  prdata = dtf_pkg::PDATA_W'(cfg.sectors_first);
      dtf_pkg::REG_PRECOMP_FIRST:  prdata = dtf_pkg::PDATA_W'(cfg.precomp_first);
      dtf_pkg::REG_HEADS_SECOND:   prdata = dtf_pkg::PDATA_W'(cfg.heads_second);
      dtf_pkg::REG_SECTORS_SECOND: prdata = dtf_pkg::PDATA_W'(cfg.sectors_second);
      dtf_pkg::REG_PRECOMP_SECOND: prdata = dtf_pkg::PDATA_W'(cfg.precomp_second);
      default:                     prdata = '0;
    endcase
  end

  dtf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .request  (request),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  dtf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .head_job (head_job),
    .empty    (q_empty)
  );

  dtf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head_job (head_job),
    .q_empty  (q_empty),
    .pop      (pop),
    .result   (result)
  );

endmodule

### hw/rtl/dtf_divider.sv
// Shared restoring divider: one quotient bit per cycle, step count given at start.
module dtf_divider (
  input  logic              clk,
  input  logic              rst,
  input  dtf_pkg::div_req_t req,
  output dtf_pkg::div_rsp_t rsp
);

  logic [dtf_pkg::SECTOR_W-1:0] quo;
  logic [dtf_pkg::TRACK_W-1:0]  rem;
  logic [dtf_pkg::TRACK_W-1:0]  divisor;
  logic [dtf_pkg::STEP_W-1:0]   cnt;
  logic                         busy;
  logic                         done;

  logic [dtf_pkg::TRACK_W:0] trial;
  logic [dtf_pkg::TRACK_W:0] diff;
  logic                      ge;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    trial = {rem, quo[dtf_pkg::SECTOR_W-1]};
    diff  = trial - {1'b0, divisor};
    ge    = (trial >= {1'b0, divisor});
  end

  // Control: load on start, count down the steps, pulse done after the last
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == dtf_pkg::STEP_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - dtf_pkg::STEP_W'(1);
        if (cnt == dtf_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath: quotient bits shift into the dividend register
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      quo <= {quo[dtf_pkg::SECTOR_W-2:0], ge};
      rem <= ge ? diff[dtf_pkg::TRACK_W-1:0] : trial[dtf_pkg::TRACK_W-1:0];
    end
  end

  assign rsp.busy      = busy;
  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

### hw/rtl/dtf_front.sv
// Front part: accepts request words, runs the checks, keeps the partition table.
module dtf_front (
  input  logic          clk,
  input  logic          rst,
  input  dtf_pkg::cfg_t cfg,
  dtf_req_if.sink       request,
  input  logic          q_full,
  output logic          push,
  output dtf_pkg::job_t push_job
);

  logic [dtf_pkg::WORD_W-1:0] part_base   [dtf_pkg::DEVICE_SLOTS];
  logic [dtf_pkg::WORD_W-1:0] part_length [dtf_pkg::DEVICE_SLOTS];

  logic                          accept;
  logic                          dev_ok;
  logic [dtf_pkg::SLOT_W-1:0]    slot;
  logic                          drive;
  logic [dtf_pkg::WORD_W-1:0]    base_sel;
  logic [dtf_pkg::WORD_W-1:0]    length_sel;
  logic [dtf_pkg::SECIDX_W-1:0]  sec_idx;
  logic [dtf_pkg::SECTOR_W-1:0]  sec_end;
  logic [dtf_pkg::SECTOR_W-1:0]  sec_abs;
  logic                          aligned;
  logic [dtf_pkg::HEADS_W-1:0]   heads;
  logic [dtf_pkg::SECS_W-1:0]    secs;
  logic [dtf_pkg::BYTE_W-1:0]    precomp;
  logic [dtf_pkg::SECTOR_W-1:0]  round_sum;
  logic [dtf_pkg::SECTOR_W-1:0]  round_base;
  logic [dtf_pkg::SECTOR_W-1:0]  adjust;
  logic [dtf_pkg::WORD_W-1:0]    new_length;
  logic                          load_write;

  assign request.ready = !q_full;
  assign accept        = request.valid && !q_full;

  // Table lookup and request arithmetic
  always_comb begin
    dev_ok     = (request.device < dtf_pkg::DEV_W'(dtf_pkg::DEVICE_SLOTS));
    slot       = request.device[dtf_pkg::SLOT_W-1:0];
    drive      = (request.device >= dtf_pkg::DEV_W'(dtf_pkg::SLOTS_PER_DRIVE));
    base_sel   = dev_ok ? part_base[slot] : '0;
    length_sel = dev_ok ? part_length[slot] : '0;
    sec_idx    = request.byte_offset[dtf_pkg::OFFSET_W-1:dtf_pkg::SECTOR_SHIFT];
    sec_end    = dtf_pkg::SECTOR_W'(sec_idx) + dtf_pkg::SECTOR_W'(dtf_pkg::PER_BLOCK);
    sec_abs    = dtf_pkg::SECTOR_W'(sec_idx) + {1'b0, base_sel};
    aligned    = (request.byte_offset[dtf_pkg::BLOCK_SHIFT-1:0] == '0);
    // Select geometry of the addressed drive, zero reads as one
    heads      = drive ? cfg.heads_second   : cfg.heads_first;
    secs       = drive ? cfg.sectors_second : cfg.sectors_first;
    precomp    = drive ? cfg.precomp_second : cfg.precomp_first;
    if (heads == '0) heads = dtf_pkg::HEADS_W'(1);
    if (secs == '0)  secs  = dtf_pkg::SECS_W'(1);
  end

  // Round the partition start up to a whole block and shrink the size
  always_comb begin
    round_sum  = {1'b0, request.entry_start} + dtf_pkg::SECTOR_W'(dtf_pkg::PER_BLOCK - 1);
    round_base = round_sum & ~dtf_pkg::SECTOR_W'(dtf_pkg::PER_BLOCK - 1);
    adjust     = round_base - {1'b0, request.entry_start};
    new_length = ({1'b0, request.entry_length} >= adjust)
                 ? request.entry_length - adjust[dtf_pkg::WORD_W-1:0] : '0;
  end

  // Classify the word in check order
  always_comb begin
    load_write         = 1'b0;
    push_job.immediate = 1'b1;
    push_job.status    = dtf_pkg::ST_OK;
    push_job.drive     = drive;
    push_job.write     = (request.command == dtf_pkg::CMD_WRITE);
    push_job.precomp   = precomp;
    push_job.heads     = heads;
    push_job.secs      = secs;
    push_job.sector    = sec_abs;
    priority if (request.command == dtf_pkg::CMD_INVALID) begin
      push_job.status = dtf_pkg::ST_EINVAL;
    end else if (request.command == dtf_pkg::CMD_LOAD) begin
      if (dev_ok) begin
        load_write = 1'b1;
      end else begin
        push_job.status = dtf_pkg::ST_EIO;
      end
    end else if (!dev_ok) begin
      push_job.status = dtf_pkg::ST_EIO;
    end else if (request.byte_count != dtf_pkg::COUNT_W'(dtf_pkg::BLOCK_BYTES)) begin
      push_job.status = dtf_pkg::ST_EINVAL;
    end else if ({1'b0, drive} >= cfg.drive_count) begin
      push_job.status = dtf_pkg::ST_EIO;
    end else if (!aligned) begin
      push_job.status = dtf_pkg::ST_EINVAL;
    end else if (sec_end > {1'b0, length_sel}) begin
      push_job.status = dtf_pkg::ST_EOF;
    end else begin
      push_job.immediate = 1'b0;
    end
  end

  assign push = accept;

  // Update the partition table on an accepted load
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < dtf_pkg::DEVICE_SLOTS; i++) begin
        part_base[i]   <= '0;
        part_length[i] <= '0;
      end
    end else if (accept && load_write) begin
      part_base[slot]   <= round_base[dtf_pkg::WORD_W-1:0];
      part_length[slot] <= new_length;
    end
  end

endmodule

### hw/rtl/dtf_queue.sv
// Short queue of classified words between the front and back parts.
module dtf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dtf_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output dtf_pkg::job_t head_job,
  output logic          empty
);

  dtf_pkg::job_t              slots [dtf_pkg::QUEUE_DEPTH];
  logic [dtf_pkg::QPTR_W-1:0] wr_ptr;
  logic [dtf_pkg::QPTR_W-1:0] rd_ptr;
  logic [dtf_pkg::QCNT_W-1:0] count;

  assign full     = (count == dtf_pkg::QCNT_W'(dtf_pkg::QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign head_job = slots[rd_ptr];

  function automatic logic [dtf_pkg::QPTR_W-1:0] wrap_inc(
    input logic [dtf_pkg::QPTR_W-1:0] ptr
  );
    if (ptr == dtf_pkg::QPTR_W'(dtf_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return ptr + dtf_pkg::QPTR_W'(1);
  endfunction

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= wrap_inc(wr_ptr);
      if (pop && !empty) rd_ptr <= wrap_inc(rd_ptr);
      unique case ({push && !full, pop && !empty})
        2'b10:   count <= count + dtf_pkg::QCNT_W'(1);
        2'b01:   count <= count - dtf_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

### hw/rtl/dtf_back.sv
// Back part: geometry division on the shared divider and the result register.
module dtf_back (
  input  logic          clk,
  input  logic          rst,
  input  dtf_pkg::job_t head_job,
  input  logic          q_empty,
  output logic          pop,
  dtf_res_if.source     result
);

  dtf_pkg::back_state_t state, state_next;
  dtf_pkg::div_req_t    div_req;
  dtf_pkg::div_rsp_t    div_rsp;

  dtf_pkg::job_t                job;
  logic [dtf_pkg::CYL_W-1:0]    cyl;
  logic [dtf_pkg::HEADS_W-1:0]  head;
  logic [dtf_pkg::SECS_W-1:0]   snum;

  logic out_free;
  logic take_job;
  logic take_cyl;
  logic take_head;
  logic load_imm;
  logic load_calc;

  logic res_valid;

  dtf_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign out_free = !res_valid || result.ready;

  // Sequence one word through the two division passes, or straight out if immediate
  always_comb begin
    state_next       = state;
    pop              = 1'b0;
    take_job         = 1'b0;
    take_cyl         = 1'b0;
    take_head        = 1'b0;
    load_imm         = 1'b0;
    load_calc        = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = head_job.sector;
    div_req.divisor  = {{(dtf_pkg::TRACK_W-dtf_pkg::HEADS_W){1'b0}}, head_job.heads}
                     * {{(dtf_pkg::TRACK_W-dtf_pkg::SECS_W){1'b0}}, head_job.secs};
    div_req.steps    = dtf_pkg::STEP_W'(dtf_pkg::SECTOR_W);
    unique case (state)
      dtf_pkg::BACK_IDLE: begin
        if (!q_empty) begin
          if (head_job.immediate) begin
            if (out_free) begin
              pop      = 1'b1;
              load_imm = 1'b1;
            end
          end else begin
            pop           = 1'b1;
            take_job      = 1'b1;
            div_req.start = 1'b1;
            state_next    = dtf_pkg::BACK_CYL;
          end
        end
      end
      dtf_pkg::BACK_CYL: begin
        // Remainder of the track division splits into head and sector
        div_req.dividend = {div_rsp.remainder,
                            {(dtf_pkg::SECTOR_W-dtf_pkg::TRACK_W){1'b0}}};
        div_req.divisor  = {{(dtf_pkg::TRACK_W-dtf_pkg::SECS_W){1'b0}}, job.secs};
        div_req.steps    = dtf_pkg::STEP_W'(dtf_pkg::TRACK_W);
        if (div_rsp.done) begin
          take_cyl      = 1'b1;
          div_req.start = 1'b1;
          state_next    = dtf_pkg::BACK_HEAD;
        end
      end
      dtf_pkg::BACK_HEAD: begin
        if (div_rsp.done) begin
          take_head  = 1'b1;
          state_next = dtf_pkg::BACK_HOLD;
        end
      end
      dtf_pkg::BACK_HOLD: begin
        if (out_free) begin
          load_calc  = 1'b1;
          state_next = dtf_pkg::BACK_IDLE;
        end
      end
      default: state_next = dtf_pkg::BACK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dtf_pkg::BACK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the word and the partial results of each pass
  always_ff @(posedge clk) begin
    if (take_job)  job  <= head_job;
    if (take_cyl)  cyl  <= div_rsp.quotient[dtf_pkg::CYL_W-1:0];
    if (take_head) begin
      head <= div_rsp.quotient[dtf_pkg::HEADS_W-1:0];
      snum <= div_rsp.remainder[dtf_pkg::SECS_W-1:0] + dtf_pkg::SECS_W'(1);
    end
  end

  // Result register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_imm || load_calc) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result register payload: errors and loads carry only the status
  always_ff @(posedge clk) begin
    if (load_imm) begin
      result.status        <= head_job.status;
      result.control_byte  <= '0;
      result.precomp_byte  <= '0;
      result.sector_count  <= '0;
      result.sector_number <= '0;
      result.cylinder_low  <= '0;
      result.cylinder_high <= '0;
      result.drive_head    <= '0;
      result.opcode_byte   <= '0;
    end else if (load_calc) begin
      result.status        <= dtf_pkg::ST_OK;
      result.control_byte  <= {head[3], 3'b000};
      result.precomp_byte  <= job.precomp;
      result.sector_count  <= dtf_pkg::BYTE_W'(dtf_pkg::PER_BLOCK);
      result.sector_number <= snum;
      result.cylinder_low  <= cyl[7:0];
      result.cylinder_high <= cyl[9:8];
      result.drive_head    <= dtf_pkg::DH_BASE | {3'b000, job.drive, 4'b0000}
                            | {3'b000, head};
      result.opcode_byte   <= job.write ? dtf_pkg::OP_WRITE : dtf_pkg::OP_READ;
    end
  end

  assign result.valid = res_valid;

  // Divider completes only while a pass is in flight
  a_done_in_pass: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == dtf_pkg::BACK_CYL || state == dtf_pkg::BACK_HEAD))
    else $error("divider done outside a division pass");

  // Divider is quiet whenever the back part is idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == dtf_pkg::BACK_IDLE) |-> !div_rsp.busy)
    else $error("divider busy while back part idle");

  // Never pop an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_empty)
    else $error("pop from empty queue");

  // A new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (load_imm || load_calc) |-> (!res_valid || result.ready))
    else $error("result register overwritten");

endmodule

### sim/dtf_task_file_checker.sv
// Checker for the disk request task-file block: tracks registers, predicts and compares words.
module dtf_task_file_checker import dtf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  dtf_req_if                 request,
  dtf_res_if                 result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output int                 mismatch_count,
  output int                 words_in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t           status;
    logic [3:0]        control_byte;
    logic [BYTE_W-1:0] precomp_byte;
    logic [BYTE_W-1:0] sector_count;
    logic [BYTE_W-1:0] sector_number;
    logic [BYTE_W-1:0] cylinder_low;
    logic [1:0]        cylinder_high;
    logic [BYTE_W-1:0] drive_head;
    logic [BYTE_W-1:0] opcode_byte;
  } task_file_t;

  cfg_t              geometry;
  logic [WORD_W-1:0] slot_base   [DEVICE_SLOTS];
  logic [WORD_W-1:0] slot_length [DEVICE_SLOTS];
  task_file_t        awaited_words [$];

  initial begin
    mismatch_count  = 0;
    words_in_flight = 0;
  end

  // Work out the task-file word of one request; a load also updates the slot tables
  function automatic task_file_t predict_task_file(input cmd_t cmd,
                                                   input logic [DEV_W-1:0] dev,
                                                   input logic [COUNT_W-1:0] count,
                                                   input logic [OFFSET_W-1:0] offset,
                                                   input logic [WORD_W-1:0] start,
                                                   input logic [WORD_W-1:0] length);
    task_file_t          tf;
    logic                drive;
    logic [HEADS_W-1:0]  heads;
    logic [SECS_W-1:0]   secs;
    logic [BYTE_W-1:0]   precomp;
    logic [SECTOR_W-1:0] sector;
    logic [TRACK_W-1:0]  track;
    logic [SECTOR_W-1:0] cyl;
    logic [HEADS_W-1:0]  head;
    logic [SECS_W-1:0]   snum;
    logic [WORD_W:0]     rounded;
    logic [WORD_W-1:0]   shortfall;
    tf = '0;
    case (cmd)
      CMD_INVALID: tf.status = ST_EINVAL;
      CMD_LOAD: begin
        if (dev >= DEVICE_SLOTS) begin
          tf.status = ST_EIO;
        end else begin
          // Round the start up to a whole block, shrink the size to match
          shortfall = '0;
          rounded   = {1'b0, start};
          if (start % PER_BLOCK != 0) begin
            shortfall = PER_BLOCK - start % PER_BLOCK;
            rounded   = start + shortfall;
          end
          slot_base[dev]   = rounded[WORD_W-1:0];
          slot_length[dev] = (length >= shortfall) ? length - shortfall : '0;
          tf.status = ST_OK;
        end
      end
      default: begin
        if (dev >= DEVICE_SLOTS) begin
          tf.status = ST_EIO;
        end else if (count != BLOCK_BYTES) begin
          tf.status = ST_EINVAL;
        end else if (dev / SLOTS_PER_DRIVE >= geometry.drive_count) begin
          tf.status = ST_EIO;
        end else if (offset % BLOCK_BYTES != 0) begin
          tf.status = ST_EINVAL;
        end else begin
          sector = offset / SECTOR_BYTES;
          if (sector + PER_BLOCK > slot_length[dev]) begin
            tf.status = ST_EOF;
          end else begin
            drive = 1'(dev / SLOTS_PER_DRIVE);
            if (drive) begin
              heads   = geometry.heads_second;
              secs    = geometry.sectors_second;
              precomp = geometry.precomp_second;
            end else begin
              heads   = geometry.heads_first;
              secs    = geometry.sectors_first;
              precomp = geometry.precomp_first;
            end
            // Zero geometry counts as one
            if (heads == 0) heads = 1;
            if (secs == 0) secs = 1;
            sector = sector + slot_base[dev];
            track  = heads * secs;
            cyl    = sector / track;
            head   = (sector % track) / secs;
            snum   = sector % secs + 1;
            tf.status        = ST_OK;
            tf.control_byte  = {head[3], 3'b000};
            tf.precomp_byte  = precomp;
            tf.sector_count  = BYTE_W'(PER_BLOCK);
            tf.sector_number = snum;
            tf.cylinder_low  = cyl[7:0];
            tf.cylinder_high = cyl[9:8];
            tf.drive_head    = DH_BASE | {3'b000, drive, 4'b0000} | {3'b000, head};
            tf.opcode_byte   = (cmd == CMD_READ) ? OP_READ : OP_WRITE;
          end
        end
      end
    endcase
    return tf;
  endfunction

  function automatic int field_differs(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    task_file_t want;
    if (rst) begin
      geometry = '{drive_count: 2'd0, heads_first: 5'd1, sectors_first: 8'd1,
                   precomp_first: 8'd0, heads_second: 5'd1, sectors_second: 8'd1,
                   precomp_second: 8'd0};
      for (int i = 0; i < DEVICE_SLOTS; i++) begin
        slot_base[i]   = '0;
        slot_length[i] = '0;
      end
      awaited_words.delete();
    end else begin
      // Track register writes
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_W-1:2]))
          REG_DRIVE_COUNT:    geometry.drive_count    = pwdata[1:0];
          REG_HEADS_FIRST:    geometry.heads_first    = pwdata[HEADS_W-1:0];
          REG_SECTORS_FIRST:  geometry.sectors_first  = pwdata[SECS_W-1:0];
          REG_PRECOMP_FIRST:  geometry.precomp_first  = pwdata[BYTE_W-1:0];
          REG_HEADS_SECOND:   geometry.heads_second   = pwdata[HEADS_W-1:0];
          REG_SECTORS_SECOND: geometry.sectors_second = pwdata[SECS_W-1:0];
          REG_PRECOMP_SECOND: geometry.precomp_second = pwdata[BYTE_W-1:0];
          default: ;
        endcase
      end
      // Compare each accepted task-file word with the oldest prediction
      if (result.valid && result.ready) begin
        if (awaited_words.size() == 0) begin
          $error("task-file word with none awaited, status %0d", result.status);
          mismatch_count++;
        end else begin
          want = awaited_words.pop_front();
          mismatch_count += field_differs("status", want.status, result.status);
          mismatch_count += field_differs("control_byte", want.control_byte,
                                          result.control_byte);
          mismatch_count += field_differs("precomp_byte", want.precomp_byte,
                                          result.precomp_byte);
          mismatch_count += field_differs("sector_count", want.sector_count,
                                          result.sector_count);
          mismatch_count += field_differs("sector_number", want.sector_number,
                                          result.sector_number);
          mismatch_count += field_differs("cylinder_low", want.cylinder_low,
                                          result.cylinder_low);
          mismatch_count += field_differs("cylinder_high", want.cylinder_high,
                                          result.cylinder_high);
          mismatch_count += field_differs("drive_head", want.drive_head, result.drive_head);
          mismatch_count += field_differs("opcode_byte", want.opcode_byte,
                                          result.opcode_byte);
        end
      end
      // Predict each accepted request word
      if (request.valid && request.ready) begin
        awaited_words.push_back(predict_task_file(cmd_t'(request.command), request.device,
                                                  request.byte_count, request.byte_offset,
                                                  request.entry_start,
                                                  request.entry_length));
      end
    end
    words_in_flight = awaited_words.size();
  end

endmodule

### sim/tb_disk_request_to_chs_task_file.sv
// Testbench top for the disk request task-file block: clock, reset, stimulus and verdict.
module tb_disk_request_to_chs_task_file;
  timeunit 1ns;
  timeprecision 1ps;
  import dtf_pkg::*;

  localparam int STALL_LIMIT      = 5000;
  localparam int HOLD_CYCLES      = 300;
  localparam int RANDOM_PER_PHASE = 120;
  localparam int SETTLE_CYCLES    = 60;

  typedef struct packed {
    cmd_t                command;
    logic [DEV_W-1:0]    device;
    logic [COUNT_W-1:0]  byte_count;
    logic [OFFSET_W-1:0] byte_offset;
    logic [WORD_W-1:0]   entry_start;
    logic [WORD_W-1:0]   entry_length;
  } disk_request_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel, penable, pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 send_idle_pct;
  int                 recv_stall_pct;
  logic               hold_request;
  logic               hold_done;
  int                 mismatch_count;
  int                 words_in_flight;
  int                 quiet_cycles;

  dtf_req_if request ();
  dtf_res_if result ();

  disk_request_to_chs_task_file dut (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  dtf_task_file_checker task_file_check (
    .clk             (clk),
    .rst             (rst),
    .request         (request),
    .result          (result),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .mismatch_count  (mismatch_count),
    .words_in_flight (words_in_flight)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Drop the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (request.valid && request.ready) || (result.valid && result.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: stall at random, hold off once for a long stretch on request
  initial begin
    result.ready = 1'b0;
    hold_done    = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        result.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done <= 1'b1;
      end
      result.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic disk_request_t make_request(input cmd_t cmd, input int unsigned dev,
                                                 input int unsigned count,
                                                 input int unsigned offset,
                                                 input int unsigned start,
                                                 input int unsigned length);
    disk_request_t w;
    w.command      = cmd;
    w.device       = DEV_W'(dev);
    w.byte_count   = COUNT_W'(count);
    w.byte_offset  = OFFSET_W'(offset);
    w.entry_start  = start;
    w.entry_length = length;
    return w;
  endfunction

  // Mostly well-formed loads and block requests, the rest noise
  function automatic disk_request_t random_request();
    disk_request_t w;
    int            pick;
    pick           = $urandom_range(99);
    w.command      = cmd_t'($urandom_range(1));
    w.device       = ($urandom_range(9) == 0) ? DEV_W'($urandom_range(15))
                                              : DEV_W'($urandom_range(DEVICE_SLOTS - 1));
    w.byte_count   = ($urandom_range(9) == 0) ? COUNT_W'($urandom) : COUNT_W'(BLOCK_BYTES);
    w.entry_start  = ($urandom_range(1) == 0) ? $urandom : $urandom_range(1000);
    w.entry_length = $urandom;
    if (pick < 15) begin
      w.command = CMD_LOAD;
      if ($urandom_range(9) < 5) begin
        w.entry_length = $urandom_range(64);
      end else if ($urandom_range(9) < 4) begin
        w.entry_length = $urandom_range(3);
      end
    end else if (pick < 20) begin
      w.command = CMD_INVALID;
    end
    if ($urandom_range(9) == 0) begin
      w.byte_offset = OFFSET_W'($urandom);
    end else if ($urandom_range(9) < 7) begin
      w.byte_offset = OFFSET_W'($urandom_range(40) * BLOCK_BYTES);
    end else begin
      w.byte_offset = OFFSET_W'($urandom) & ~OFFSET_W'(BLOCK_BYTES - 1);
    end
    return w;
  endfunction

  // Offer one word and hold it until accepted; called and returning at a falling edge
  task automatic send_request(input disk_request_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      request.valid <= 1'b0;
      @(negedge clk);
    end
    request.valid        <= 1'b1;
    request.command      <= w.command;
    request.device       <= w.device;
    request.byte_count   <= w.byte_count;
    request.byte_offset  <= w.byte_offset;
    request.entry_start  <= w.entry_start;
    request.entry_length <= w.entry_length;
    @(posedge clk);
    while (!request.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Write all drive registers; noisy sets junk in the unused upper bits
  task automatic program_drives(input logic [1:0] count, input logic [4:0] heads_a,
                                input logic [7:0] secs_a, input logic [7:0] precomp_a,
                                input logic [4:0] heads_b, input logic [7:0] secs_b,
                                input logic [7:0] precomp_b, input bit noisy);
    logic [PDATA_W-1:0] junk;
    junk = noisy ? $urandom : '0;
    write_register(REG_DRIVE_COUNT,    {junk[31:2], count});
    write_register(REG_HEADS_FIRST,    {junk[31:5], heads_a});
    write_register(REG_SECTORS_FIRST,  {junk[31:8], secs_a});
    write_register(REG_PRECOMP_FIRST,  {junk[31:8], precomp_a});
    write_register(REG_HEADS_SECOND,   {junk[31:5], heads_b});
    write_register(REG_SECTORS_SECOND, {junk[31:8], secs_b});
    write_register(REG_PRECOMP_SECOND, {junk[31:8], precomp_b});
  endtask

  task automatic program_random_drives();
    logic [1:0] count;
    count = ($urandom_range(3) == 0) ? 2'($urandom_range(3)) : 2'd2;
    program_drives(count, 5'($urandom_range(31)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 5'($urandom_range(31)),
                   8'($urandom_range(255)), 8'($urandom_range(255)), 1'b1);
  endtask

  // Drop valid and wait until every awaited word is back
  task automatic drain();
    request.valid <= 1'b0;
    @(negedge clk);
    while (words_in_flight != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Idling mode: 0 none, 1 sender idle, 2 receiver stalls, 3 both
  task automatic set_idling(input int mode);
    send_idle_pct  = (mode == 1) ? 88 : (mode == 3) ? 37 : 0;
    recv_stall_pct <= (mode == 2) ? 88 : (mode == 3) ? 37 : 0;
  endtask

  task automatic run_random(input int mode);
    set_idling(mode);
    repeat (RANDOM_PER_PHASE) send_request(random_request());
    drain();
  endtask

  initial begin
    disk_request_t directed [$];
    rst                  = 1'b1;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    hold_request         = 1'b0;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    request.valid        = 1'b0;
    request.command      = CMD_READ;
    request.device       = '0;
    request.byte_count   = '0;
    request.byte_offset  = '0;
    request.entry_start  = '0;
    request.entry_length = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset geometry: no drives attached
    send_request(make_request(CMD_READ, 0, BLOCK_BYTES, 0, 0, 0));
    send_request(make_request(CMD_INVALID, 15, 'hFFFF, 'h7FFF_FFFF, 'hFFFF_FFFF,
                              'hFFFF_FFFF));
    send_request(make_request(CMD_LOAD, 3, 0, 0, 7, 9));
    send_request(make_request(CMD_LOAD, 12, 0, 0, 5, 5));
    drain();

    // Directed corners: largest first drive, one-sector second drive
    program_drives(2'd2, 5'd16, 8'd255, 8'd255, 5'd1, 8'd1, 8'd0, 1'b0);
    directed.push_back(make_request(CMD_LOAD, 0, 0, 0, 0, 'hFFFF_FFFF));
    directed.push_back(make_request(CMD_READ, 0, BLOCK_BYTES, 0, 0, 0));
    directed.push_back(make_request(CMD_WRITE, 0, BLOCK_BYTES, 'h7FFF_FC00, 0, 0));
    // start round-up wraps, size clamps to zero
    directed.push_back(make_request(CMD_LOAD, 5, 0, 0, 'hFFFF_FFFF, 0));
    directed.push_back(make_request(CMD_READ, 5, BLOCK_BYTES, 0, 0, 0));
    // absolute sector beyond 32 bits, cylinder truncated
    directed.push_back(make_request(CMD_LOAD, 6, 0, 0, 'hFFFF_FFFE, 'hFFFF_FFFF));
    directed.push_back(make_request(CMD_WRITE, 6, BLOCK_BYTES, 'h7FFF_FC00, 0, 0));
    // partition end: last block fits, next one does not
    directed.push_back(make_request(CMD_LOAD, 7, 0, 0, 3, 5));
    directed.push_back(make_request(CMD_READ, 7, BLOCK_BYTES, BLOCK_BYTES, 0, 0));
    directed.push_back(make_request(CMD_READ, 7, BLOCK_BYTES, 2 * BLOCK_BYTES, 0, 0));
    directed.push_back(make_request(CMD_READ, 10, BLOCK_BYTES, 0, 0, 0));
    directed.push_back(make_request(CMD_WRITE, 15, BLOCK_BYTES, 0, 0, 0));
    directed.push_back(make_request(CMD_READ, 0, BLOCK_BYTES - 1, 0, 0, 0));
    directed.push_back(make_request(CMD_WRITE, 0, 'hFFFF, 0, 0, 0));
    directed.push_back(make_request(CMD_READ, 0, 0, 0, 0, 0));
    directed.push_back(make_request(CMD_READ, 0, BLOCK_BYTES, SECTOR_BYTES, 0, 0));
    directed.push_back(make_request(CMD_WRITE, 0, BLOCK_BYTES, 'h7FFF_FFFF, 0, 0));
    directed.push_back(make_request(CMD_LOAD, 9, 0, 0, 'h8000_0001, 1));
    directed.push_back(make_request(CMD_READ, 3, BLOCK_BYTES, 0, 0, 0));
    directed.push_back(make_request(CMD_LOAD, 15, 0, 0, 'hFFFF_FFFF, 'hFFFF_FFFF));
    foreach (directed[i]) send_request(directed[i]);
    drain();

    // Random phases; the first one also holds off the receiver to fill the block
    program_drives(2'd2, 5'd1, 8'd1, 8'd0, 5'd16, 8'd255, 8'd255, 1'b0);
    hold_request <= 1'b1;
    run_random(0);
    // zero sectors, heads past the field, second drive absent
    program_drives(2'd1, 5'd31, 8'd0, 8'h5A, 5'd0, 8'd0, 8'h33, 1'b0);
    run_random(1);
    program_drives(2'd3, 5'd0, 8'd17, 8'd128, 5'd31, 8'd255, 8'd1, 1'b1);
    run_random(2);
    program_random_drives();
    run_random(3);
    program_random_drives();
    run_random(0);

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && words_in_flight == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
